>>> hw/rtl/npml_pkg.sv
// Shared types, constants and the microcode program of the nearest point map lookup.
package npml_pkg;

	localparam int DEF_MAX_SPEED_POINTS = 32;
	localparam int DEF_MAX_TORQUE_ROWS = 32;

	localparam int VAL_W = 32;
	localparam int IDX_W = 5;
	localparam int CNT_W = 6;
	localparam int DIST_W = VAL_W + 1;
	localparam int S_TDATA_W = 112;
	localparam int M_TDATA_W = 48;

	localparam logic [CNT_W-1:0] COUNT_RESET = 6'd32;

	// Reciprocal of 100 scaled by 2^37, rounded up; exact for any 32-bit magnitude.
	localparam logic [VAL_W-1:0] DIV100_MAGIC = 32'h51EB851F;
	localparam int DIV100_SHIFT = 37;

	typedef enum logic [1:0] {
		OP_WR_SPEED = 2'd0,
		OP_WR_TORQUE = 2'd1,
		OP_WR_EFF = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic {
		REG_SPEED_POINTS = 1'b0,
		REG_TORQUE_ROWS = 1'b1
	} reg_idx_t;

	typedef enum logic {
		SCAN_SPEED = 1'b0,
		SCAN_TORQUE = 1'b1
	} scan_t;

	typedef enum logic [2:0] {
		COND_NEVER = 3'd0,
		COND_ALWAYS = 3'd1,
		COND_ACCEPT = 3'd2,
		COND_WRITE = 3'd3,
		COND_SCAN_DONE = 3'd4,
		COND_OUT_FREE = 3'd5
	} cond_t;

	typedef enum logic [3:0] {
		STEP_IDLE = 4'd0,
		STEP_DISPATCH = 4'd1,
		STEP_SPD_SCAN = 4'd2,
		STEP_TRQ_CLR = 4'd3,
		STEP_TRQ_SCAN = 4'd4,
		STEP_EFF_RD = 4'd5,
		STEP_EFF_MAG = 4'd6,
		STEP_MUL = 4'd7,
		STEP_RESP_Q = 4'd8,
		STEP_WRITE = 4'd9,
		STEP_RESP_W = 4'd10
	} step_t;

	typedef struct packed {
		logic in_ready;
		logic clr_cnt;
		logic scan_en;
		scan_t scan_kind;
		logic wr_en;
		logic mag_en;
		logic mul_en;
		logic out_load;
		logic out_query;
		cond_t cond;
		logic hold;
		step_t target;
	} ctrl_word_t;

	typedef struct packed {
		logic accept;
		logic is_write;
		logic scan_done;
		logic out_free;
	} status_t;

	function automatic ctrl_word_t ucode(input step_t s);
		ctrl_word_t w;
		begin
			w = ctrl_word_t'('0);
			w.cond = COND_NEVER;
			w.scan_kind = SCAN_SPEED;
			w.target = STEP_IDLE;
			case (s)
				STEP_IDLE: begin
					w.in_ready = 1'b1;
					w.clr_cnt = 1'b1;
					w.cond = COND_ACCEPT;
					w.target = STEP_DISPATCH;
					w.hold = 1'b1;
				end
				STEP_DISPATCH: begin
					w.cond = COND_WRITE;
					w.target = STEP_WRITE;
				end
				STEP_SPD_SCAN: begin
					w.scan_en = 1'b1;
					w.scan_kind = SCAN_SPEED;
					w.cond = COND_SCAN_DONE;
					w.target = STEP_TRQ_CLR;
					w.hold = 1'b1;
				end
				STEP_TRQ_CLR: begin
					w.clr_cnt = 1'b1;
					w.scan_kind = SCAN_TORQUE;
				end
				STEP_TRQ_SCAN: begin
					w.scan_en = 1'b1;
					w.scan_kind = SCAN_TORQUE;
					w.cond = COND_SCAN_DONE;
					w.target = STEP_EFF_RD;
					w.hold = 1'b1;
				end
				STEP_EFF_RD: begin
					w.scan_kind = SCAN_TORQUE;
				end
				STEP_EFF_MAG: begin
					w.mag_en = 1'b1;
				end
				STEP_MUL: begin
					w.mul_en = 1'b1;
				end
				STEP_RESP_Q: begin
					w.out_load = 1'b1;
					w.out_query = 1'b1;
					w.cond = COND_OUT_FREE;
					w.target = STEP_IDLE;
					w.hold = 1'b1;
				end
				STEP_WRITE: begin
					w.wr_en = 1'b1;
				end
				STEP_RESP_W: begin
					w.out_load = 1'b1;
					w.cond = COND_OUT_FREE;
					w.target = STEP_IDLE;
					w.hold = 1'b1;
				end
				default: begin
					w.cond = COND_ALWAYS;
					w.target = STEP_IDLE;
				end
			endcase
			return w;
		end
	endfunction

endpackage

>>> hw/rtl/nearest_point_map_lookup_core.sv
// The speed scan and the column scan each read one map entry per cycle from one RAM port.
// The input is ready for the next beat in the cycle after the previous result enters the output register.
// Reset clears the sequencer, scan control and output valid and sets both counts to 32.
// The map memories are not cleared and hold no data until written.
module nearest_point_map_lookup_core #(
	parameter int MAX_SPEED_POINTS = npml_pkg::DEF_MAX_SPEED_POINTS,
	parameter int MAX_TORQUE_ROWS = npml_pkg::DEF_MAX_TORQUE_ROWS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// row, col, load_value, query_speed, query_torque, zero fill
	input  logic [npml_pkg::S_TDATA_W-1:0] s_tdata,
	// op
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// efficiency_fraction, speed_index, torque_index, zero fill
	output logic [npml_pkg::M_TDATA_W-1:0] m_tdata,
	// answer_valid
	output logic m_tuser,
	input  logic cfg_we,
	input  logic cfg_addr,
	input  logic [npml_pkg::CNT_W-1:0] cfg_wdata
);
	import npml_pkg::*;

	ctrl_word_t ctrl;
	status_t status;

	npml_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.status(status),
		.ctrl(ctrl)
	);

	npml_dp #(
		.MAX_SPEED_POINTS(MAX_SPEED_POINTS),
		.MAX_TORQUE_ROWS(MAX_TORQUE_ROWS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.status(status),
		.s_tvalid(s_tvalid),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	assign s_tready = ctrl.in_ready;
endmodule

>>> hw/rtl/npml_ram.sv
// Generic single write port, single read port RAM with registered read data.
module npml_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> hw/rtl/npml_seq.sv
// Microcode sequencer: step counter, program ROM and conditional jumps.
module npml_seq (
	input  logic clk,
	input  logic arst_n,
	input  npml_pkg::status_t status,
	output npml_pkg::ctrl_word_t ctrl
);
	import npml_pkg::*;

	step_t step_q;
	step_t step_d;
	logic cond_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		ctrl = ucode(step_q);
		case (ctrl.cond)
			COND_NEVER: cond_ok = 1'b0;
			COND_ALWAYS: cond_ok = 1'b1;
			COND_ACCEPT: cond_ok = status.accept;
			COND_WRITE: cond_ok = status.is_write;
			COND_SCAN_DONE: cond_ok = status.scan_done;
			COND_OUT_FREE: cond_ok = status.out_free;
			default: cond_ok = 1'b0;
		endcase
		if (cond_ok) begin
			step_d = ctrl.target;
		end else if (ctrl.hold) begin
			step_d = step_q;
		end else begin
			step_d = step_t'(step_q + 4'd1);
		end
	end

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		status.accept |=> step_q == STEP_DISPATCH)
		else $error("accepted beat did not move the sequencer to dispatch");
endmodule

>>> hw/rtl/npml_dp.sv
// Datapath: map memories, nearest point scan, divide by 100 and result register.
module npml_dp #(
	parameter int MAX_SPEED_POINTS = npml_pkg::DEF_MAX_SPEED_POINTS,
	parameter int MAX_TORQUE_ROWS = npml_pkg::DEF_MAX_TORQUE_ROWS
) (
	input  logic clk,
	input  logic arst_n,
	input  npml_pkg::ctrl_word_t ctrl,
	output npml_pkg::status_t status,
	input  logic s_tvalid,
	input  logic [npml_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [npml_pkg::M_TDATA_W-1:0] m_tdata,
	output logic m_tuser,
	input  logic cfg_we,
	input  logic cfg_addr,
	input  logic [npml_pkg::CNT_W-1:0] cfg_wdata
);
	import npml_pkg::*;

	localparam int GRID_DEPTH = MAX_SPEED_POINTS * MAX_TORQUE_ROWS;
	localparam int SA_W = (MAX_SPEED_POINTS > 1) ? $clog2(MAX_SPEED_POINTS) : 1;
	localparam int GA_W = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;

	function automatic logic [GA_W-1:0] grid_addr(input logic [CNT_W-1:0] r,
		input logic [CNT_W-1:0] c);
		int unsigned t;
		begin
			t = 32'(r) * 32'(MAX_SPEED_POINTS) + 32'(c);
			return GA_W'(t);
		end
	endfunction

	logic [CNT_W-1:0] spd_pts_q, trq_rows_q;
	logic [CNT_W-1:0] ns, nt, n_sel;

	op_t op_q;
	logic [IDX_W-1:0] row_q, col_q;
	logic [VAL_W-1:0] load_q, qs_q, qt_q;
	logic accept;
	logic col_ok, row_ok;

	logic sp_we, tq_we, ef_we;
	logic [VAL_W-1:0] sp_rdata, tq_rdata, ef_rdata;

	logic [CNT_W-1:0] cnt_q;
	logic issue;
	logic pend_s1, pend_s2;
	logic [CNT_W-1:0] idx_s1, idx_s2;
	logic [DIST_W-1:0] dist_s2, best_q;
	logic [VAL_W-1:0] scan_val, scan_ref;
	logic signed [DIST_W-1:0] diff;
	logic [DIST_W-1:0] dist_now;
	logic take;
	logic [CNT_W-1:0] si_q, ti_q;

	logic neg_q;
	logic [VAL_W-1:0] mag_q;
	logic [2*VAL_W-1:0] prod_q;
	logic [VAL_W-1:0] quot, frac;

	logic m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic m_tuser_q;
	logic out_free;

	// Configuration registers and effective counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_pts_q <= COUNT_RESET;
			trq_rows_q <= COUNT_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_SPEED_POINTS: spd_pts_q <= cfg_wdata;
				REG_TORQUE_ROWS: trq_rows_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (spd_pts_q == '0) begin
			ns = CNT_W'(1);
		end else if (32'(spd_pts_q) > 32'(MAX_SPEED_POINTS)) begin
			ns = CNT_W'(MAX_SPEED_POINTS);
		end else begin
			ns = spd_pts_q;
		end
		if (trq_rows_q == '0) begin
			nt = CNT_W'(1);
		end else if (32'(trq_rows_q) > 32'(MAX_TORQUE_ROWS)) begin
			nt = CNT_W'(MAX_TORQUE_ROWS);
		end else begin
			nt = trq_rows_q;
		end
		n_sel = (ctrl.scan_kind == SCAN_SPEED) ? ns : nt;
	end

	// Input beat capture.
	assign accept = s_tvalid && ctrl.in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_WR_SPEED;
		end else if (accept) begin
			op_q <= op_t'(s_tuser);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= s_tdata[4:0];
			col_q <= s_tdata[9:5];
			load_q <= s_tdata[41:10];
			qs_q <= s_tdata[73:42];
			qt_q <= s_tdata[105:74];
		end
	end

	// Map memories.
	assign col_ok = 32'(col_q) < 32'(MAX_SPEED_POINTS);
	assign row_ok = 32'(row_q) < 32'(MAX_TORQUE_ROWS);
	assign sp_we = ctrl.wr_en && (op_q == OP_WR_SPEED) && col_ok;
	assign tq_we = ctrl.wr_en && (op_q == OP_WR_TORQUE) && col_ok && row_ok;
	assign ef_we = ctrl.wr_en && (op_q == OP_WR_EFF) && col_ok && row_ok;

	npml_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SPEED_POINTS)) u_speed_ram (
		.clk(clk),
		.we(sp_we),
		.waddr(SA_W'(col_q)),
		.wdata(load_q),
		.raddr(SA_W'(cnt_q)),
		.rdata(sp_rdata)
	);

	npml_ram #(.WIDTH(VAL_W), .DEPTH(GRID_DEPTH)) u_torque_ram (
		.clk(clk),
		.we(tq_we),
		.waddr(grid_addr({1'b0, row_q}, {1'b0, col_q})),
		.wdata(load_q),
		.raddr(grid_addr(cnt_q, si_q)),
		.rdata(tq_rdata)
	);

	npml_ram #(.WIDTH(VAL_W), .DEPTH(GRID_DEPTH)) u_eff_ram (
		.clk(clk),
		.we(ef_we),
		.waddr(grid_addr({1'b0, row_q}, {1'b0, col_q})),
		.wdata(load_q),
		.raddr(grid_addr(ti_q, si_q)),
		.rdata(ef_rdata)
	);

	// Scan: issue one read per cycle, distance in the next, compare in the one after.
	assign issue = ctrl.scan_en && (cnt_q < n_sel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pend_s1 <= 1'b0;
			pend_s2 <= 1'b0;
		end else begin
			if (ctrl.clr_cnt) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			pend_s1 <= issue;
			pend_s2 <= pend_s1;
		end
	end

	always_comb begin
		scan_val = (ctrl.scan_kind == SCAN_SPEED) ? sp_rdata : tq_rdata;
		scan_ref = (ctrl.scan_kind == SCAN_SPEED) ? qs_q : qt_q;
		diff = DIST_W'(signed'(scan_val)) - DIST_W'(signed'(scan_ref));
		dist_now = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
		take = pend_s2 && ((idx_s2 == '0) || (dist_s2 < best_q));
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		idx_s2 <= idx_s1;
		dist_s2 <= dist_now;
		if (take) begin
			best_q <= dist_s2;
			if (ctrl.scan_kind == SCAN_SPEED) begin
				si_q <= idx_s2;
			end else begin
				ti_q <= idx_s2;
			end
		end
	end

	// Truncating divide by 100 through a reciprocal multiply on the magnitude.
	always_ff @(posedge clk) begin
		if (ctrl.mag_en) begin
			neg_q <= ef_rdata[VAL_W-1];
			mag_q <= ef_rdata[VAL_W-1] ? (~ef_rdata + VAL_W'(1)) : ef_rdata;
		end
		if (ctrl.mul_en) begin
			prod_q <= (2*VAL_W)'(mag_q) * (2*VAL_W)'(DIV100_MAGIC);
		end
	end

	assign quot = VAL_W'(prod_q >> DIV100_SHIFT);
	assign frac = neg_q ? (~quot + VAL_W'(1)) : quot;

	// Result register.
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.out_load && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load && out_free) begin
			m_tuser_q <= ctrl.out_query;
			if (ctrl.out_query) begin
				m_tdata_q <= M_TDATA_W'({ti_q[IDX_W-1:0], si_q[IDX_W-1:0], frac});
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	assign status.accept = accept;
	assign status.is_write = op_q != OP_QUERY;
	assign status.scan_done = pend_s2 && (idx_s2 == n_sel - CNT_W'(1));
	assign status.out_free = out_free;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s2 |-> idx_s2 < n_sel)
		else $error("scan compare index beyond the count in use");

	a_speed_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.scan_en && ctrl.scan_kind == SCAN_SPEED && status.scan_done)
		|=> si_q < ns)
		else $error("chosen speed column beyond the speed points in use");

	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tuser_q) |-> m_tdata_q == '0)
		else $error("write acknowledgement carries a nonzero payload");
endmodule
